FILE: sv/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and codes for the ordered list engine: command and status
// codes, the cell data-select code and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;

  // command codes carried by a request
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_SEARCH  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_REVERSE = 3'd3,
    CMD_DISPLAY = 3'd4
  } cmd_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_REVERSED  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_ELEMENT   = 3'd7;

  // where a cell takes its next value from
  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_LEFT  = 2'd1,  // neighbour towards the front (cell 0: the key)
    SEL_RIGHT = 2'd2,  // neighbour towards the back
    SEL_FRONT = 2'd3   // broadcast of cell 0
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t sel;
    logic      cmp_en;  // capture key compare this cycle
    logic      valid;   // cell lies below the fill count
  } cell_ctl_t;

endpackage

FILE: sv/ole_cmd_if.sv
// ----------------------------------------------------------------------------
// ole_cmd_if
// Command channel: valid/ready handshake with command code and operand.
// ----------------------------------------------------------------------------
interface ole_cmd_if import ole_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] operand_value;

  modport source (output valid, output cmd, output operand_value, input ready);
  modport sink   (input valid, input cmd, input operand_value, output ready);

endinterface

FILE: sv/ole_res_if.sv
// ----------------------------------------------------------------------------
// ole_res_if
// Result channel: valid/ready handshake with status, element and last flag.
// ----------------------------------------------------------------------------
interface ole_res_if import ole_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] element_value;
  logic                     last;

  modport source (output valid, output status, output element_value, output last,
                  input ready);
  modport sink   (input valid, input status, input element_value, input last,
                  output ready);

endinterface

FILE: sv/ole_cell.sv
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds a value, takes a neighbour's value on shifts, and
// compares against the broadcast key, feeding a front-to-back match chain.
// ----------------------------------------------------------------------------
module ole_cell import ole_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] key,
  input  logic [DATA_W-1:0] left_value,
  input  logic [DATA_W-1:0] right_value,
  input  logic [DATA_W-1:0] front_value,
  input  logic              match_before,
  output logic [DATA_W-1:0] value,
  output logic              match_through
);

  logic match;

  always_ff @(posedge clk) begin
    case (ctl.sel)
      SEL_LEFT:  value <= left_value;
      SEL_RIGHT: value <= right_value;
      SEL_FRONT: value <= front_value;
      default:   value <= value;
    endcase
    if (ctl.cmp_en) begin
      match <= (value == key);
    end
  end

  // any valid hit at this slot or nearer the front
  assign match_through = match_before | (match & ctl.valid);

endmodule

FILE: sv/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_chan carries one request: cmd (insert, search, delete, reverse,
//   display) and operand_value. res_chan returns result items: status,
//   element_value (only for display elements, else zero) and last, set on
//   the final result of each request.
//   Requests are taken one at a time; cmd_chan.ready is high only while the
//   engine is idle. Unused command codes are taken and dropped silently.
//   Search and delete register the per-cell compares before the result;
//   reverse makes one rotation of the cell chain per step; display gives
//   one element per cycle while the result register is free, and the chain
//   comes full circle.
//   A single-result request loads its result into the output reg on the
//   edge the engine returns to idle; display loads its last element there.
//   The result register decouples the channels: a finished result may wait
//   there while the next request is accepted. If the receiver stalls, a step
//   that loads the result register holds until it frees up; reverse rotation
//   steps carry on regardless.
//   Reset (rst, synchronous) empties the list and drops any pending result;
//   cell contents are not cleared, the fill count masks them.
// ----------------------------------------------------------------------------
module ordered_list_engine import ole_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  ole_cmd_if.sink   cmd_chan,
  ole_res_if.source res_chan
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_CMP,
    S_FIN,
    S_REV,
    S_DISP
  } state_t;

  state_t              state;
  logic [CMD_W-1:0]    cmd_q;
  logic [DATA_W-1:0]   key;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    rev_m;      // upper bound of the current rotate step
  logic [IDX_W-1:0]    disp_idx;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0]   out_value;
  logic                out_last;

  cell_ctl_t           ctl [DEPTH];
  logic [DATA_W-1:0]   cell_value [DEPTH];
  logic [DEPTH-1:0]    match_through;

  logic                can_emit;
  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [DATA_W-1:0]   emit_value;
  logic                emit_last;
  logic                full;
  logic                found;
  logic [IDX_W-1:0]    last_idx;

  assign can_emit = !out_valid || res_chan.ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign found    = match_through[DEPTH-1];
  assign last_idx = IDX_W'(count - CNT_W'(1));

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    logic              match_in;

    if (g == 0) begin : g_head
      assign left_v   = key;        // insert feeds the key into the front
      assign match_in = 1'b0;
    end else begin : g_body
      assign left_v   = cell_value[g-1];
      assign match_in = match_through[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_v = cell_value[g];
    end else begin : g_inner
      assign right_v = cell_value[g+1];
    end

    ole_cell u_cell (
      .clk           (clk),
      .ctl           (ctl[g]),
      .key           (key),
      .left_value    (left_v),
      .right_value   (right_v),
      .front_value   (cell_value[0]),
      .match_before  (match_in),
      .value         (cell_value[g]),
      .match_through (match_through[g])
    );
  end

  // Per-cell selects: insert shifts back, delete closes the gap behind the
  // first hit, reverse and display rotate cell 0 to the end of a window.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].valid  = (CNT_W'(i) < count);
      ctl[i].cmp_en = (state == S_CMP);
      ctl[i].sel    = SEL_HOLD;
      case (state)
        S_INS: begin
          if (can_emit && !full) ctl[i].sel = SEL_LEFT;
        end
        S_FIN: begin
          if (can_emit && cmd_q == CMD_DELETE && found && match_through[i]) begin
            ctl[i].sel = SEL_RIGHT;
          end
        end
        S_REV: begin
          if (rev_m != '0) begin
            if (IDX_W'(i) < rev_m)       ctl[i].sel = SEL_RIGHT;
            else if (IDX_W'(i) == rev_m) ctl[i].sel = SEL_FRONT;
          end
        end
        S_DISP: begin
          if (can_emit && count != '0) begin
            if (IDX_W'(i) < last_idx)       ctl[i].sel = SEL_RIGHT;
            else if (IDX_W'(i) == last_idx) ctl[i].sel = SEL_FRONT;
          end
        end
        default: ctl[i].sel = SEL_HOLD;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result generation
  // --------------------------------------------------------------------------
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_EMPTY;
    emit_value  = '0;
    emit_last   = 1'b1;
    case (state)
      S_INS: begin
        emit        = can_emit;
        emit_status = full ? ST_FULL : ST_INSERTED;
      end
      S_FIN: begin
        emit = can_emit;
        if (cmd_q == CMD_SEARCH)  emit_status = found ? ST_FOUND : ST_NOT_FOUND;
        else if (count == '0)     emit_status = ST_EMPTY;
        else                      emit_status = found ? ST_DELETED : ST_NOT_FOUND;
      end
      S_REV: begin
        emit        = can_emit && (rev_m == '0);
        emit_status = ST_REVERSED;
      end
      S_DISP: begin
        emit = can_emit;
        if (count != '0) begin
          emit_status = ST_ELEMENT;
          emit_value  = cell_value[0];
          emit_last   = (disp_idx == last_idx);
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid  <= 1'b1;
        out_status <= emit_status;
        out_value  <= emit_value;
        out_last   <= emit_last;
      end else if (res_chan.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_chan.valid) begin
            cmd_q <= cmd_chan.cmd;
            key   <= cmd_chan.operand_value;
            unique case (cmd_chan.cmd) inside
              CMD_INSERT: state <= S_INS;
              CMD_SEARCH, CMD_DELETE: state <= S_CMP;
              CMD_REVERSE: begin
                rev_m <= (count == '0) ? '0 : last_idx;
                state <= S_REV;
              end
              CMD_DISPLAY: begin
                disp_idx <= '0;
                state    <= S_DISP;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_INS: begin
          if (can_emit) begin
            if (!full) count <= count + CNT_W'(1);
            state <= S_IDLE;
          end
        end
        S_CMP: state <= S_FIN;
        S_FIN: begin
          if (can_emit) begin
            if (cmd_q == CMD_DELETE && found) count <= count - CNT_W'(1);
            state <= S_IDLE;
          end
        end
        S_REV: begin
          if (rev_m != '0) begin
            rev_m <= rev_m - IDX_W'(1);
          end else if (can_emit) begin
            state <= S_IDLE;
          end
        end
        S_DISP: begin
          if (can_emit) begin
            if (count == '0 || disp_idx == last_idx) state <= S_IDLE;
            else disp_idx <= disp_idx + IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd_chan.ready         = (state == S_IDLE);
  assign res_chan.valid         = out_valid;
  assign res_chan.status        = out_status;
  assign res_chan.element_value = out_value;
  assign res_chan.last          = out_last;

endmodule

FILE: bench/ole_list_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ole_list_check
// Watches both channels of the ordered list engine. Keeps its own copy of the
// list, works out the replies each accepted request should give, and compares
// every accepted result, field by field, with the oldest reply still due.
// ----------------------------------------------------------------------------
module ole_list_check import ole_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  ole_cmd_if   cmd_mon,
  ole_res_if   res_mon,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   element_value;
    logic                last;
  } reply_t;

  logic [DATA_W-1:0] list_model[$];   // front of the list at index 0
  reply_t            due_replies[$];
  int                mismatches = 0;

  function automatic int find_first(logic [DATA_W-1:0] key);
    foreach (list_model[i]) if (list_model[i] == key) return i;
    return -1;
  endfunction

  function automatic void push_reply(logic [STATUS_W-1:0] code, logic [DATA_W-1:0] value,
                                     logic last_flag);
    reply_t r;
    r.status        = code;
    r.element_value = value;
    r.last          = last_flag;
    due_replies.push_back(r);
  endfunction

  function automatic void apply_command(logic [CMD_W-1:0] code, logic [DATA_W-1:0] value);
    int                pos;
    logic [DATA_W-1:0] flipped[$];
    pos = find_first(value);
    case (code)
      CMD_INSERT: begin
        if (list_model.size() >= DEPTH) begin
          push_reply(ST_FULL, '0, 1'b1);
        end else begin
          list_model.push_front(value);
          push_reply(ST_INSERTED, '0, 1'b1);
        end
      end
      CMD_SEARCH: push_reply((pos >= 0) ? ST_FOUND : ST_NOT_FOUND, '0, 1'b1);
      CMD_DELETE: begin
        if (list_model.size() == 0) begin
          push_reply(ST_EMPTY, '0, 1'b1);
        end else if (pos < 0) begin
          push_reply(ST_NOT_FOUND, '0, 1'b1);
        end else begin
          list_model.delete(pos);
          push_reply(ST_DELETED, '0, 1'b1);
        end
      end
      CMD_REVERSE: begin
        foreach (list_model[i]) flipped.push_front(list_model[i]);
        list_model = flipped;
        push_reply(ST_REVERSED, '0, 1'b1);
      end
      CMD_DISPLAY: begin
        if (list_model.size() == 0) begin
          push_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          foreach (list_model[i])
            push_reply(ST_ELEMENT, list_model[i], i == list_model.size() - 1);
        end
      end
      default: ;  // spare codes: dropped, no reply
    endcase
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      list_model.delete();
      due_replies.delete();
    end else begin
      // results first: nothing accepted on this edge can answer a request
      // taken on the same edge
      if (res_mon.valid && res_mon.ready) begin
        if (due_replies.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing due: status %0d element %0d last %0b",
                   $time, res_mon.status, $signed(res_mon.element_value), res_mon.last);
        end else begin
          want = due_replies.pop_front();
          if (res_mon.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, res_mon.status);
          end
          if (res_mon.element_value !== want.element_value) begin
            mismatches++;
            $display("%0t: element_value expected %0d, got %0d",
                     $time, $signed(want.element_value), $signed(res_mon.element_value));
          end
          if (res_mon.last !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0b, got %0b", $time, want.last, res_mon.last);
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) apply_command(cmd_mon.cmd, cmd_mon.operand_value);
    end
    fail_count  <= mismatches;
    outstanding <= due_replies.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the ordered list engine bench. Drives requests and result back
// pressure; the list checker beside the engine predicts and compares. A short
// directed run covers the empty, single-entry, duplicate and spare-code cases,
// then random traffic in fill, mixed and drain spells pushes the list to full
// and back to empty.
// ----------------------------------------------------------------------------
module tb import ole_pkg::*; ();

  localparam int DEPTH          = 16;
  localparam int REQUEST_TARGET = 180;     // random requests that do something
  localparam int CALM_FROM      = 150;     // no idling on either side after this
  localparam int PAUSE_AT       = 90;      // sender waits for a full drain here
  localparam int SPELL_LEN      = 25;      // requests per traffic spell
  localparam int SETTLE_CYCLES  = 40;      // > longest request sequence
  localparam int CYCLE_LIMIT    = 500000;

  // codes the engine takes and drops
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef enum int {
    SPELL_FILL,
    SPELL_MIXED,
    SPELL_DRAIN
  } spell_t;

  logic clk = 1'b0;
  logic rst;
  bit   calm = 1'b0;
  int   cycles = 0;
  int   fail_count;
  int   outstanding;

  // operands are mostly drawn from here so that searches and deletes hit
  logic [DATA_W-1:0] value_pool [8];

  ole_cmd_if cmd_chan ();
  ole_res_if res_chan ();

  ordered_list_engine #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_chan (cmd_chan),
    .res_chan (res_chan)
  );

  ole_list_check #(.DEPTH(DEPTH)) list_check (
    .clk         (clk),
    .rst         (rst),
    .cmd_mon     (cmd_chan),
    .res_mon     (res_chan),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side back pressure: random stall bursts between ready runs
  initial begin : result_pacing
    int hold;
    res_chan.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        res_chan.ready <= 1'b0;
        hold = $urandom_range(1, 13);
        repeat (hold) @(posedge clk);
      end
      res_chan.ready <= 1'b1;
      hold = $urandom_range(1, 20);
      repeat (hold) @(posedge clk);
    end
  end

  // Present one request and hold it until the engine takes it. Called on a
  // rising edge; returns on the edge of the handshake with valid still high,
  // so back-to-back requests keep valid up without a dip.
  task automatic send_request(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] value);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      cmd_chan.valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    cmd_chan.valid         <= 1'b1;
    cmd_chan.cmd           <= code;
    cmd_chan.operand_value <= value;
    @(posedge clk);
    while (!cmd_chan.ready) @(posedge clk);
  endtask

  // drop valid and wait for every due reply to come back
  task automatic wait_drained();
    cmd_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(spell_t spell);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return CMD_SPARE_FIRST + 3'($urandom_range(0, 2));
    case (spell)
      SPELL_FILL: begin
        if (roll < 80) return CMD_INSERT;
        if (roll < 90) return CMD_DISPLAY;
        return CMD_SEARCH;
      end
      SPELL_DRAIN: begin
        if (roll < 70) return CMD_DELETE;
        if (roll < 85) return CMD_DISPLAY;
        if (roll < 92) return CMD_SEARCH;
        return CMD_REVERSE;
      end
      default: begin
        if (roll < 30) return CMD_INSERT;
        if (roll < 50) return CMD_SEARCH;
        if (roll < 70) return CMD_DELETE;
        if (roll < 82) return CMD_REVERSE;
        return CMD_DISPLAY;
      end
    endcase
  endfunction

  initial begin : stimulus
    int               counted;
    bit               paused;
    logic [CMD_W-1:0] code;

    rst                    <= 1'b1;
    cmd_chan.valid         <= 1'b0;
    cmd_chan.cmd           <= CMD_INSERT;
    cmd_chan.operand_value <= '0;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int k = 4; k < 8; k++) value_pool[k] = $urandom();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- directed part -----------------------------------------------------
    // every command against an empty list
    send_request(CMD_DISPLAY, 32'h0000_0000);
    send_request(CMD_DELETE,  32'h0000_0001);
    send_request(CMD_SEARCH,  32'h0000_0001);
    send_request(CMD_REVERSE, 32'hffff_ffff);
    // single entry, then reverse of a one-entry list
    send_request(CMD_INSERT,  32'h8000_0000);
    send_request(CMD_REVERSE, 32'h0000_0000);
    // extremes, with a duplicate so delete must take the frontmost match
    send_request(CMD_INSERT,  32'h7fff_ffff);
    send_request(CMD_INSERT,  32'h0000_0000);
    send_request(CMD_INSERT,  32'hffff_ffff);
    send_request(CMD_INSERT,  32'h7fff_ffff);
    send_request(CMD_DISPLAY, 32'hffff_ffff);
    send_request(CMD_SEARCH,  32'h8000_0000);
    send_request(CMD_SEARCH,  32'h7fff_fffe);  // one bit off a stored value
    send_request(CMD_DELETE,  32'h7fff_ffff);
    send_request(CMD_DELETE,  32'h0000_0001);  // no match
    send_request(CMD_DISPLAY, 32'h0000_0000);
    send_request(CMD_REVERSE, 32'h0000_0000);
    send_request(CMD_DISPLAY, 32'h0000_0000);
    // spare codes are swallowed with no reply
    send_request(CMD_SPARE_FIRST,      32'h1234_5678);
    send_request(CMD_SPARE_FIRST + 3'd1, 32'hffff_ffff);
    send_request(CMD_SPARE_LAST,       32'h8000_0000);
    send_request(CMD_DELETE,  32'h8000_0000);
    send_request(CMD_DISPLAY, 32'h0000_0000);
    wait_drained();

    // --- random part: fill, mixed and drain spells in turn -----------------
    counted = 0;
    paused  = 1'b0;
    for (int n = 0; counted < REQUEST_TARGET; n++) begin
      calm = (counted >= CALM_FROM);
      if (!paused && counted >= PAUSE_AT) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) value_pool[$urandom_range(0, 7)] = $urandom();
      code = pick_command(spell_t'((n / SPELL_LEN) % 3));
      if (code <= CMD_DISPLAY) counted++;
      send_request(code, pick_value());
    end

    calm = 1'b1;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
